>>> design/lz77wd_pkg.sv
// shared types and constants of the lz77 window decompressor
`default_nettype none

package lz77wd_pkg;

   localparam int WINDOW_BYTES = 4096;
   localparam int PTR_BITS     = $clog2(WINDOW_BYTES);
   localparam int COUNT_BITS   = 24;

   localparam logic [7:0]          HEADER_TYPE = 8'h10;
   localparam logic [3:0]          GROUP_BITS  = 4'd8;
   localparam logic [4:0]          MIN_MATCH   = 5'd3;
   localparam logic [4:0]          MAX_COPY    = 5'd18;
   localparam logic [PTR_BITS-1:0] PTR_LAST    = PTR_BITS'(WINDOW_BYTES - 1);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_FLAG   = 3'd1,
      PH_DATA   = 3'd2,
      PH_REF2   = 3'd3
   } phase_type;

endpackage

`default_nettype wire

>>> design/lz77wd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lz77wd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/lz77_window_decompressor_unit.sv
// lz77 window decompressor top level with history memory and copy pipeline
//
// req_ carries one compressed byte per transaction: a 4-byte header, then flag
// bytes each followed by up to eight literals or two-byte back-references.
// rsp_ carries one decompressed byte per transaction; a bad type byte gives a
// single transaction with header_error set. end_of_run marks the last
// transaction caused by one input byte, end_of_output the byte that completes
// csr_output_length bytes, after which a new header is expected.
// a literal or error shows on rsp_ the cycle after it is taken; header, flag
// and first reference bytes give nothing. a back-reference of n bytes (3 to
// 18) reads the history ram once per byte and streams one byte per cycle
// while rsp_ready is high, through the read address, ram read and output
// registers; req_ready stays low until the last byte has left the pipeline.
// the ram read latency and the single read port set that rate.
// history entries never written since reset read as zero through a fill
// mark, so no clearing pass follows reset; reset returns to header phase
// with output length 1.
// when rsp_ready is low the copy pipeline holds its byte and req_ready drops
// until the output register frees; csr_ writes are taken at any time.
`default_nettype none

module lz77_window_decompressor_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_out_byte,
   output logic             rsp_end_of_run,
   output logic             rsp_end_of_output,
   output logic             rsp_header_error,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_output_length
);

   localparam int PB = lz77wd_pkg::PTR_BITS;
   localparam int CB = lz77wd_pkg::COUNT_BITS;

   lz77wd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]    hidx_ff, hidx_in;
   logic [7:0]    flags_ff, flags_in;
   logic [3:0]    bits_left_ff, bits_left_in;
   logic [4:0]    plen_ff, plen_in;
   logic [3:0]    pdh_ff, pdh_in;
   logic [PB-1:0] wp_ff, wp_in;
   logic          full_ff, full_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] olen_ff, olen_in;
   logic [4:0]    rd_left_ff, rd_left_in;
   logic [PB-1:0] rd_addr_ff, rd_addr_in;
   logic          dist_one_ff, dist_one_in;
   logic          w_valid_ff, w_valid_in;
   logic          w_last_ff, w_last_in;
   logic          w_fwd_ff, w_fwd_in;
   logic          w_zero_ff, w_zero_in;
   logic [7:0]    last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_eor_ff, rsp_eor_in;
   logic          rsp_eoo_ff, rsp_eoo_in;
   logic          rsp_err_ff, rsp_err_in;

   logic          out_free, busy, req_fire, w_adv, rd_issue;
   logic          prod_en, prod_last, prod_done, err_en;
   logic [7:0]    prod_byte, w_byte, ram_rdata;
   logic [CB-1:0] count_next;
   logic [11:0]   ref_offset;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign busy      = (rd_left_ff != 5'd0) || w_valid_ff;
   assign req_ready = !busy && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign w_adv     = w_valid_ff && out_free;
   assign rd_issue  = (rd_left_ff != 5'd0) && (!w_valid_ff || w_adv);
   assign w_byte    = w_fwd_ff ? last_ff : (w_zero_ff ? 8'd0 : ram_rdata);
   assign count_next = count_ff + CB'(1);
   assign ref_offset = {pdh_ff, req_in_byte};

   lz77wd_ram #(
      .WIDTH(8),
      .DEPTH(lz77wd_pkg::WINDOW_BYTES)
   ) u_history (
      .clock   (clock),
      .wr_en   (prod_en),
      .wr_addr (wp_ff),
      .wr_data (prod_byte),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      phase_in     = phase_ff;
      hidx_in      = hidx_ff;
      flags_in     = flags_ff;
      bits_left_in = bits_left_ff;
      plen_in      = plen_ff;
      pdh_in       = pdh_ff;
      wp_in        = wp_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      olen_in      = csr_valid ? csr_output_length : olen_ff;
      rd_left_in   = rd_left_ff;
      rd_addr_in   = rd_addr_ff;
      dist_one_in  = dist_one_ff;
      w_valid_in   = w_valid_ff;
      w_last_in    = w_last_ff;
      w_fwd_in     = w_fwd_ff;
      w_zero_in    = w_zero_ff;
      last_in      = last_ff;
      prod_en      = 1'b0;
      prod_last    = 1'b0;
      prod_byte    = req_in_byte;
      err_en       = 1'b0;

      // copy pipeline: read stage then produce stage
      if (w_adv) begin
         prod_en    = 1'b1;
         prod_byte  = w_byte;
         prod_last  = w_last_ff;
         w_valid_in = 1'b0;
      end
      if (rd_issue) begin
         rd_left_in = rd_left_ff - 5'd1;
         rd_addr_in = rd_addr_ff + PB'(1);
         w_valid_in = 1'b1;
         w_last_in  = (rd_left_ff == 5'd1);
         w_fwd_in   = dist_one_ff && w_valid_ff;
         w_zero_in  = !(full_ff || (rd_addr_ff < wp_ff));
      end

      if (req_fire) begin
         case (phase_ff)
            lz77wd_pkg::PH_FLAG: begin
               flags_in     = req_in_byte;
               bits_left_in = lz77wd_pkg::GROUP_BITS;
               phase_in     = lz77wd_pkg::PH_DATA;
            end
            lz77wd_pkg::PH_DATA: begin
               flags_in     = {flags_ff[6:0], 1'b0};
               bits_left_in = bits_left_ff - 4'd1;
               if (flags_ff[7]) begin
                  plen_in  = {1'b0, req_in_byte[7:4]} + lz77wd_pkg::MIN_MATCH;
                  pdh_in   = req_in_byte[3:0];
                  phase_in = lz77wd_pkg::PH_REF2;
               end else begin
                  phase_in  = (bits_left_in == 4'd0) ? lz77wd_pkg::PH_FLAG
                                                     : lz77wd_pkg::PH_DATA;
                  prod_en   = 1'b1;
                  prod_last = 1'b1;
                  prod_byte = req_in_byte;
               end
            end
            lz77wd_pkg::PH_REF2: begin
               phase_in    = (bits_left_ff == 4'd0) ? lz77wd_pkg::PH_FLAG
                                                    : lz77wd_pkg::PH_DATA;
               rd_left_in  = plen_ff;
               rd_addr_in  = wp_ff - ref_offset - PB'(1);
               dist_one_in = (ref_offset == 12'd0);
            end
            default: begin
               phase_in = lz77wd_pkg::PH_HEADER;
               if (hidx_ff == 2'd0) begin
                  if (req_in_byte != lz77wd_pkg::HEADER_TYPE) begin
                     err_en = 1'b1;
                  end else begin
                     count_in = '0;
                     hidx_in  = 2'd1;
                  end
               end else begin
                  hidx_in = hidx_ff + 2'd1;
                  if (hidx_in == 2'd0) begin
                     phase_in = lz77wd_pkg::PH_FLAG;
                  end
               end
            end
         endcase
      end

      prod_done = prod_en && (count_next == olen_ff);
      if (prod_en) begin
         wp_in    = wp_ff + PB'(1);
         full_in  = full_ff || (wp_ff == lz77wd_pkg::PTR_LAST);
         count_in = count_next;
         last_in  = prod_byte;
      end
      if (prod_done) begin
         phase_in   = lz77wd_pkg::PH_HEADER;
         hidx_in    = 2'd0;
         rd_left_in = 5'd0;
         w_valid_in = 1'b0;
      end

      rsp_byte_in = prod_byte;
      rsp_eor_in  = prod_last || prod_done;
      rsp_eoo_in  = prod_done;
      rsp_err_in  = 1'b0;
      if (err_en) begin
         rsp_byte_in = 8'd0;
         rsp_eor_in  = 1'b1;
         rsp_eoo_in  = 1'b0;
         rsp_err_in  = 1'b1;
      end
      if (prod_en || err_en) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lz77wd_pkg::PH_HEADER;
         hidx_ff      <= 2'd0;
         flags_ff     <= 8'd0;
         bits_left_ff <= 4'd0;
         plen_ff      <= 5'd0;
         pdh_ff       <= 4'd0;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         count_ff     <= '0;
         olen_ff      <= CB'(1);
         rd_left_ff   <= 5'd0;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         flags_ff     <= flags_in;
         bits_left_ff <= bits_left_in;
         plen_ff      <= plen_in;
         pdh_ff       <= pdh_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         olen_ff      <= olen_in;
         rd_left_ff   <= rd_left_in;
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      dist_one_ff <= dist_one_in;
      w_last_ff   <= w_last_in;
      w_fwd_ff    <= w_fwd_in;
      w_zero_ff   <= w_zero_in;
      last_ff     <= last_in;
      if (prod_en || err_en) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_eor_ff  <= rsp_eor_in;
         rsp_eoo_ff  <= rsp_eoo_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_end_of_run    = rsp_eor_ff;
   assign rsp_end_of_output = rsp_eoo_ff;
   assign rsp_header_error  = rsp_err_ff;

   // stalled copy byte stays in place with its ram data
   a_copy_hold: assert property (@(posedge clock) disable iff (reset)
      w_valid_ff && !out_free |=> w_valid_ff && $stable(ram_rdata))
      else $error("copy byte lost during output stall");

   // every produced byte advances the write pointer by one
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      prod_en |=> wp_ff == $past(wp_ff) + PB'(1))
      else $error("write pointer out of step with produced bytes");

   // no copy runs longer than the longest reference
   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      rd_left_ff <= lz77wd_pkg::MAX_COPY)
      else $error("copy length out of range");

endmodule

`default_nettype wire

>>> test/lz77wd_stream_checker.sv
// checker for the lz77 window decompressor: predicts decoded bytes and compares rsp_ transactions
`timescale 1ns / 100ps

module lz77wd_stream_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_end_of_run,
   input  wire logic        rsp_end_of_output,
   input  wire logic        rsp_header_error,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [23:0] csr_output_length,
   output int               mismatch_count,
   output int               pending_count,
   output int               checked_count,
   output int               error_count,
   output logic             at_stream_start
);

   localparam int REPORT_LIMIT = 10;
   localparam int PB = lz77wd_pkg::PTR_BITS;
   localparam int CB = lz77wd_pkg::COUNT_BITS;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       end_of_output;
      logic       header_error;
   } decoded_byte_type;

   decoded_byte_type expected_bytes [$];
   decoded_byte_type run_buf [0:17];
   int               run_n;

   logic [7:0]            window_mem [0:lz77wd_pkg::WINDOW_BYTES-1];
   logic [PB-1:0]         wr_ptr;
   logic [CB-1:0]         produced;
   logic [CB-1:0]         out_len;
   lz77wd_pkg::phase_type cur_phase;
   logic [1:0]            hdr_idx;
   logic [7:0]            flag_bits;
   logic [3:0]            bits_left;
   logic [4:0]            pend_len;
   logic [3:0]            pend_hi;

   task automatic emit_decoded_byte(input logic [7:0] v, output logic done);
      decoded_byte_type r;
      window_mem[wr_ptr] = v;
      wr_ptr = wr_ptr + 1'b1;
      produced = produced + 1'b1;
      done = (produced == out_len);
      r.out_byte = v;
      r.end_of_run = 1'b0;
      r.end_of_output = done;
      r.header_error = 1'b0;
      run_buf[run_n] = r;
      run_n++;
      if (done) begin
         cur_phase = lz77wd_pkg::PH_HEADER;
         hdr_idx = 2'd0;
      end
   endtask

   task automatic predict_compressed_byte(input logic [7:0] b);
      logic             is_ref;
      logic             done;
      logic [12:0]      ref_dist;
      logic [4:0]       cnt;
      logic [PB-1:0]    src;
      decoded_byte_type r;
      run_n = 0;
      done = 1'b0;
      case (cur_phase)
         lz77wd_pkg::PH_FLAG: begin
            flag_bits = b;
            bits_left = lz77wd_pkg::GROUP_BITS;
            cur_phase = lz77wd_pkg::PH_DATA;
         end
         lz77wd_pkg::PH_DATA: begin
            is_ref = flag_bits[7];
            flag_bits = flag_bits << 1;
            bits_left = bits_left - 1'b1;
            if (is_ref) begin
               pend_len = {1'b0, b[7:4]} + lz77wd_pkg::MIN_MATCH;
               pend_hi = b[3:0];
               cur_phase = lz77wd_pkg::PH_REF2;
            end else begin
               cur_phase = (bits_left == 4'd0) ? lz77wd_pkg::PH_FLAG : lz77wd_pkg::PH_DATA;
               emit_decoded_byte(b, done);
            end
         end
         lz77wd_pkg::PH_REF2: begin
            ref_dist = {1'b0, pend_hi, b} + 13'd1;
            cnt = (pend_len > lz77wd_pkg::MAX_COPY) ? lz77wd_pkg::MAX_COPY : pend_len;
            cur_phase = (bits_left == 4'd0) ? lz77wd_pkg::PH_FLAG : lz77wd_pkg::PH_DATA;
            for (int i = 0; i < cnt && !done; i++) begin
               src = wr_ptr - ref_dist[PB-1:0];
               emit_decoded_byte(window_mem[src], done);
            end
         end
         default: begin
            cur_phase = lz77wd_pkg::PH_HEADER;
            if (hdr_idx == 2'd0) begin
               if (b != lz77wd_pkg::HEADER_TYPE) begin
                  r.out_byte = 8'd0;
                  r.end_of_run = 1'b0;
                  r.end_of_output = 1'b0;
                  r.header_error = 1'b1;
                  run_buf[0] = r;
                  run_n = 1;
                  error_count++;
               end else begin
                  produced = '0;
                  hdr_idx = 2'd1;
               end
            end else begin
               hdr_idx = hdr_idx + 1'b1;
               if (hdr_idx == 2'd0) cur_phase = lz77wd_pkg::PH_FLAG;
            end
         end
      endcase
      if (run_n > 0) begin
         r = run_buf[run_n-1];
         r.end_of_run = 1'b1;
         run_buf[run_n-1] = r;
      end
      for (int i = 0; i < run_n; i++) expected_bytes = {expected_bytes, run_buf[i]};
   endtask

   task automatic check_response();
      decoded_byte_type want;
      decoded_byte_type got;
      got.out_byte = rsp_out_byte;
      got.end_of_run = rsp_end_of_run;
      got.end_of_output = rsp_end_of_output;
      got.header_error = rsp_header_error;
      checked_count++;
      if (expected_bytes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected rsp transaction: byte %02h run %b out %b err %b",
                     got.out_byte, got.end_of_run, got.end_of_output, got.header_error);
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("mismatch: expected byte %02h run %b out %b err %b,",
                        want.out_byte, want.end_of_run, want.end_of_output,
                        want.header_error,
                        " got byte %02h run %b out %b err %b",
                        got.out_byte, got.end_of_run, got.end_of_output,
                        got.header_error);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lz77wd_pkg::WINDOW_BYTES; i++) window_mem[i] = 8'd0;
         wr_ptr = '0;
         produced = '0;
         out_len = 24'd1;
         cur_phase = lz77wd_pkg::PH_HEADER;
         hdr_idx = 2'd0;
         flag_bits = 8'd0;
         bits_left = 4'd0;
         pend_len = 5'd0;
         pend_hi = 4'd0;
         expected_bytes.delete();
         mismatch_count = 0;
         checked_count = 0;
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) out_len = csr_output_length;
         if (req_valid && req_ready) predict_compressed_byte(req_in_byte);
         if (rsp_valid && rsp_ready) check_response();
      end
      pending_count = expected_bytes.size();
      at_stream_start = (cur_phase == lz77wd_pkg::PH_HEADER) && (hdr_idx == 2'd0);
   end

endmodule

>>> test/tb_lz77_window_decompressor_unit.sv
// testbench top for the lz77 window decompressor: stimulus, idling, pressure and verdict
`timescale 1ns / 100ps

module tb_lz77_window_decompressor_unit;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int DIRECTED_END = 29;
   localparam int PHASE_ITEMS  = 100;
   localparam int TIMEOUT_NS   = 5_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_run;
   logic        rsp_end_of_output;
   logic        rsp_header_error;
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_output_length;

   int   mismatch_count;
   int   pending_count;
   int   checked_count;
   int   error_count;
   logic at_stream_start;

   int   tx_idle_pct;
   int   rx_idle_pct;
   int   items_sent;
   int   stream_count;
   bit   hold_armed;
   bit   hold_done;

   int         gen_produced;
   int         gen_limit;
   int         gen_bits;
   logic [7:0] gen_flags;

   lz77_window_decompressor_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_output (rsp_end_of_output),
      .rsp_header_error  (rsp_header_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length)
   );

   lz77wd_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_output (rsp_end_of_output),
      .rsp_header_error  (rsp_header_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .error_count       (error_count),
      .at_stream_start   (at_stream_start)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #TIMEOUT_NS;
      $display("tb_lz77_window_decompressor_unit failed");
      $finish;
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready = ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // called and returning at a falling edge; valid stays high after the transaction
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_output_length(input logic [23:0] len);
      wait_idle();
      csr_valid = 1'b1;
      csr_output_length = len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic start_stream();
      send_byte(lz77wd_pkg::HEADER_TYPE);
      repeat (3) send_byte(8'($urandom));
      gen_produced = 0;
      gen_bits = 0;
      stream_count++;
   endtask

   task automatic send_token();
      int          ref_len;
      int          ref_dist;
      int          max_dist;
      logic [3:0]  len_code;
      logic [11:0] dist_code;
      if (gen_bits == 0) begin
         gen_flags = 8'($urandom);
         send_byte(gen_flags);
         gen_bits = 8;
      end
      if (gen_flags[7]) begin
         ref_len = $urandom_range(3, 18);
         max_dist = (gen_produced < 1) ? 1 : ((gen_produced > 64) ? 64 : gen_produced);
         ref_dist = ($urandom_range(9) == 0)
                    ? $urandom_range(1, lz77wd_pkg::WINDOW_BYTES)
                    : $urandom_range(1, max_dist);
         len_code = 4'(ref_len - 3);
         dist_code = 12'(ref_dist - 1);
         send_byte({len_code, dist_code[11:8]});
         send_byte(dist_code[7:0]);
         gen_produced += (ref_len < gen_limit - gen_produced) ? ref_len
                                                              : gen_limit - gen_produced;
      end else begin
         send_byte(8'($urandom));
         gen_produced += 1;
      end
      gen_flags = gen_flags << 1;
      gen_bits--;
   endtask

   task automatic run_tokens(input int stop_at);
      while (gen_produced < stop_at) send_token();
   endtask

   task automatic send_noise();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == lz77wd_pkg::HEADER_TYPE) b = b ^ 8'h01;
      send_byte(b);
   endtask

   // length set far away, changed once part of the stream is out
   task automatic long_stream(input logic [23:0] first_len, input int stop_at);
      int new_len;
      write_output_length(first_len);
      start_stream();
      gen_limit = 1 << lz77wd_pkg::COUNT_BITS;
      if (first_len == 24'hFFFFFF) hold_armed = 1'b1;
      run_tokens(stop_at);
      new_len = gen_produced + $urandom_range(1, 12);
      write_output_length(24'(new_len));
      gen_limit = new_len;
      run_tokens(gen_limit);
   endtask

   initial begin
      int pick;
      int len;
      int phase_end;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      csr_valid = 1'b0;
      csr_output_length = 24'd0;
      tx_idle_pct = 11;
      rx_idle_pct = 77;
      items_sent = 0;
      stream_count = 0;
      hold_armed = 1'b0;
      hold_done = 1'b0;
      gen_produced = 0;
      gen_limit = 0;
      gen_bits = 0;
      gen_flags = 8'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // bad type bytes
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h11);
      // one-byte stream at the reset length
      send_byte(lz77wd_pkg::HEADER_TYPE);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      // far reference before stream start, then a full overlapping copy
      write_output_length(24'd24);
      send_byte(lz77wd_pkg::HEADER_TYPE);
      send_byte(8'h18);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h60);
      send_byte(8'hA5);
      send_byte(8'h0F);
      send_byte(8'hFF);
      send_byte(8'hF0);
      send_byte(8'h00);
      send_byte(8'h5A);
      send_byte(8'h00);
      // length reached mid copy, remaining flag bits dropped
      write_output_length(24'd4);
      send_byte(lz77wd_pkg::HEADER_TYPE);
      send_byte(8'h04);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h40);
      send_byte(8'h33);
      send_byte(8'hF0);
      send_byte(8'h00);
      stream_count += 3;

      for (int p = 0; p < 3; p++) begin
         wait_idle();
         case (p)
            0: begin
               tx_idle_pct = 11;
               rx_idle_pct = 77;
               long_stream(24'hFFFFFF, 60);
            end
            1: begin
               tx_idle_pct = 77;
               rx_idle_pct = 11;
               long_stream(24'h000000, 24);
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         phase_end = DIRECTED_END + (p + 1) * PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               repeat ($urandom_range(1, 3)) send_noise();
            end else if (pick < 18) begin
               len = $urandom_range(8, 40);
               write_output_length(24'(len));
               start_stream();
               gen_limit = len;
               run_tokens(len / 2);
               while (!at_stream_start) send_byte(8'($urandom));
            end else begin
               len = ($urandom_range(9) < 4) ? $urandom_range(1, 8)
                                             : $urandom_range(9, 60);
               write_output_length(24'(len));
               start_stream();
               gen_limit = len;
               run_tokens(len);
            end
         end
      end

      wait_idle();
      $display("covered %0d compressed bytes over %0d streams with three idle mixes",
               items_sent, stream_count);
      $display("%0d decompressed transactions checked, %0d header errors among them",
               checked_count, error_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_lz77_window_decompressor_unit passed");
      end else begin
         $display("tb_lz77_window_decompressor_unit failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/lz77wd_pkg.sv
design/lz77wd_ram.sv
design/lz77_window_decompressor_unit.sv
test/lz77wd_stream_checker.sv
test/tb_lz77_window_decompressor_unit.sv
